/* rtl/core/qmi_pkg.sv */
// qmi_pkg: shared types and codes for the queue with middle insert
// used by qmi_ctrl, qmi_cell and queue_with_middle_insert_top
package qmi_pkg;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    // any code with this bit set is a pop
    localparam int OP_POP_BIT = 1;

    localparam int OCC_W = 7;
    localparam int OUT_W = 32;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } qmi_status_t;

    // control broadcast to every cell for one accepted word
    typedef struct packed {
        logic load_back;  // append at the first empty cell
        logic load_mid;   // insert at the first back-half cell
        logic shift_pop;  // every cell takes its right neighbor
        logic grow;       // front-half marker advances by one
        logic shrink;     // front-half marker retreats by one
    } qmi_ctrl_t;

endpackage

/* rtl/core/qmi_cell.sv */
// qmi_cell: one storage slot of the queue chain
// depends on qmi_pkg for the control struct
module qmi_cell #(
    parameter int STORE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qmi_pkg::qmi_ctrl_t    ctrl,
    input  logic [STORE_BITS-1:0] din,
    input  logic [STORE_BITS-1:0] left_data,
    input  logic                  left_valid,
    input  logic                  left_front,
    input  logic [STORE_BITS-1:0] right_data,
    input  logic                  right_valid,
    input  logic                  right_front,
    output logic [STORE_BITS-1:0] data,
    output logic                  valid,
    output logic                  front
);

    logic [STORE_BITS-1:0] data_reg;
    logic [STORE_BITS-1:0] data_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  front_reg;
    logic                  front_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.shift_pop)
        begin
            data_next = right_data;
        end
        else if (ctrl.load_back)
        begin
            if (!valid_reg && left_valid)
            begin
                data_next = din;
            end
        end
        else if (ctrl.load_mid)
        begin
            // first back-half cell takes the word, the rest shift back
            if (!front_reg && left_front)
            begin
                data_next = din;
            end
            else if (!front_reg)
            begin
                data_next = left_data;
            end
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_comb
    begin
        priority if (ctrl.shift_pop)
        begin
            valid_next = right_valid;
        end
        else if (ctrl.load_back || ctrl.load_mid)
        begin
            valid_next = valid_reg | left_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_comb
    begin
        priority if (ctrl.grow)
        begin
            front_next = front_reg | left_front;
        end
        else if (ctrl.shrink)
        begin
            front_next = right_front;
        end
        else
        begin
            front_next = front_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            front_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            front_reg <= front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign front = front_reg;

endmodule

/* rtl/core/qmi_ctrl.sv */
// qmi_ctrl: operation decode, occupancy counter and status
// depends on qmi_pkg for codes and the control struct
module qmi_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [1:0]           operation,
    output qmi_pkg::qmi_ctrl_t   ctrl,
    output qmi_pkg::qmi_status_t status_next,
    output logic [CW-1:0]        count,
    output logic [CW-1:0]        count_after
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          is_pop;
    logic          is_push;
    logic          is_insert;
    logic          empty;
    logic          full;
    logic          odd;

    assign is_pop    = operation[qmi_pkg::OP_POP_BIT];
    assign is_push   = (operation == qmi_pkg::OP_PUSH);
    assign is_insert = (operation == qmi_pkg::OP_INSERT);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(CAPACITY));
    assign odd       = count_reg[0];

    always_comb
    begin
        ctrl.load_back = fire && is_push && !full;
        ctrl.load_mid  = fire && is_insert && !full;
        ctrl.shift_pop = fire && is_pop && !empty;
        // front half holds ceil(k/2): grows on even k, shrinks on odd k
        ctrl.grow      = fire && !is_pop && !full && !odd;
        ctrl.shrink    = fire && is_pop && !empty && odd;
    end

    always_comb
    begin
        priority if (is_pop && empty)
        begin
            status_next = qmi_pkg::ST_EMPTY;
        end
        else if (is_pop)
        begin
            status_next = qmi_pkg::ST_POPPED;
        end
        else if (full)
        begin
            status_next = qmi_pkg::ST_FULL;
        end
        else
        begin
            status_next = qmi_pkg::ST_PUSHED;
        end
    end

    always_comb
    begin
        priority if (ctrl.shift_pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (ctrl.load_back || ctrl.load_mid)
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count       = count_reg;
    assign count_after = count_next;

endmodule

/* rtl/core/queue_with_middle_insert_top.sv */
// queue_with_middle_insert_top: bounded queue with push, middle insert and pop
// the result of an accepted word is in the output register from the next cycle
// one word per cycle unless out_ready stalls; cells finish any operation in one step
// the output register holds a result while the next word is accepted
// reset: asynchronous, active low; clears the occupancy count, cell flags and output valid
// depends on qmi_pkg, qmi_ctrl and qmi_cell
module queue_with_middle_insert_top #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] popped_value,
    output logic [1:0]         status,
    output logic [6:0]         occupancy
);

    localparam int STORE_BITS = (VALUE_BITS < qmi_pkg::OUT_W) ? VALUE_BITS : qmi_pkg::OUT_W;
    localparam int CW         = $clog2(CAPACITY + 1);

    logic                 fire;
    qmi_pkg::qmi_ctrl_t   ctrl;
    qmi_pkg::qmi_status_t status_next;
    logic [CW-1:0]        count;
    logic [CW-1:0]        count_after;
    logic [STORE_BITS-1:0] din;

    // padded neighbor lines: slot 0 is left of cell 0, slot CAPACITY+1 right of the last
    logic [STORE_BITS-1:0] data_ext [CAPACITY+2];
    logic [CAPACITY+1:0]   valid_ext;
    logic [CAPACITY+1:0]   front_ext;

    logic                       out_valid_reg;
    logic [qmi_pkg::OUT_W-1:0]  popped_value_reg;
    logic [qmi_pkg::OUT_W-1:0]  popped_value_next;
    qmi_pkg::qmi_status_t       status_reg;
    logic [qmi_pkg::OCC_W-1:0]  occupancy_reg;
    logic [qmi_pkg::OCC_W-1:0]  occupancy_next;
    logic [CW+qmi_pkg::OCC_W-1:0] occ_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign din      = value[STORE_BITS-1:0];

    qmi_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .operation   (operation),
        .ctrl        (ctrl),
        .status_next (status_next),
        .count       (count),
        .count_after (count_after)
    );

    assign data_ext[0]                = '0;
    assign data_ext[CAPACITY+1]       = '0;
    assign valid_ext[0]               = 1'b1;
    assign valid_ext[CAPACITY+1]      = 1'b0;
    assign front_ext[0]               = 1'b1;
    assign front_ext[CAPACITY+1]      = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        qmi_cell #(
            .STORE_BITS (STORE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .din         (din),
            .left_data   (data_ext[i]),
            .left_valid  (valid_ext[i]),
            .left_front  (front_ext[i]),
            .right_data  (data_ext[i+2]),
            .right_valid (valid_ext[i+2]),
            .right_front (front_ext[i+2]),
            .data        (data_ext[i+1]),
            .valid       (valid_ext[i+1]),
            .front       (front_ext[i+1])
        );
    end

    assign popped_value_next = ctrl.shift_pop ? qmi_pkg::OUT_W'(data_ext[1]) : '0;
    assign occ_wide          = {{qmi_pkg::OCC_W{1'b0}}, count_after};
    assign occupancy_next    = occ_wide[qmi_pkg::OCC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            popped_value_reg <= popped_value_next;
            status_reg       <= status_next;
            occupancy_reg    <= occupancy_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;

    // occupied cells form a prefix; the number of valid cells must equal the count
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_ext[CAPACITY:1]) == int'(count))
        else $error("cell valid flags disagree with occupancy count");

    // front-half marker covers ceil(count/2) cells
    a_front_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(front_ext[CAPACITY:1]) == ((int'(count) + 1) / 2))
        else $error("front-half marker out of balance");

    // a dropped push leaves the chain's valid and front flags untouched
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status_next == qmi_pkg::ST_FULL |=> $stable(valid_ext) && $stable(front_ext))
        else $error("full push changed the cell chain");

    // a successful pop delivers the old head word
    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ctrl.shift_pop |=>
            popped_value_reg == qmi_pkg::OUT_W'($past(data_ext[1])) && status_reg == qmi_pkg::ST_POPPED)
        else $error("popped word is not the queue head");

endmodule
